// File: rtl/rpn_stack_calculator_top_macros.svh
// Assertion macros for the RPN calculator.
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RPN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RPN_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPN_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RPN_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/rpn_pkg.sv
// Shared constants and types for the RPN calculator.
`timescale 1ns / 1ps
package rpn_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] OP_PUSH = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_POW  = 4'd5;
    localparam logic [3:0] OP_SQRT = 4'd6;
    localparam logic [3:0] OP_LOG  = 4'd7;
    localparam logic [3:0] OP_SEL  = 4'd8;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       start;     // start iterative unit with latched op
        logic [3:0] op;
    } rpn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic        done;
        logic        fail;
        logic [31:0] result;
    } rpn_sts_t;
endpackage

// File: rtl/rpn_ram.sv
// Generic single-port-write, one-read RAM with registered read.
`timescale 1ns / 1ps
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/rpn_alu.sv
// Iterative arithmetic datapath: one step of div/pow/sqrt/log per cycle.
`timescale 1ns / 1ps
module rpn_alu (
    input  logic             aclk,
    input  logic             aresetn,
    input  rpn_pkg::rpn_cmd_t cmd,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    input  logic [31:0]      c,
    output rpn_pkg::rpn_sts_t sts
);
    logic        busy_reg, busy_next;
    logic [3:0]  op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] x_reg, x_next;   // div: remainder; pow: acc; sqrt: n; log: k
    logic [31:0] y_reg, y_next;   // div: quotient/dividend; pow: square; sqrt: root
    logic [32:0] z_reg, z_next;   // div: divisor; pow: exponent; sqrt: bit; log: power
    logic [31:0] w_reg, w_next;   // log: base
    logic        neg_reg, neg_next;
    logic [31:0] arg_reg, arg_next;
    rpn_pkg::rpn_sts_t sts_next;

    logic [63:0] prod;
    logic [31:0] mula, mulb;
    logic [32:0] rem_sh;
    logic [31:0] abs_a, abs_b;
    logic [32:0] rb;

    assign abs_a = a[31] ? (~a + 32'd1) : a;
    assign abs_b = b[31] ? (~b + 32'd1) : b;

    always_comb begin
        mula = x_reg;
        mulb = y_reg;
        if (op_reg == rpn_pkg::OP_POW && !z_reg[0]) begin
            mula = y_reg;
        end else if (op_reg == rpn_pkg::OP_LOG) begin
            mula = z_reg[31:0];
            mulb = w_reg;
        end
    end
    assign prod = {32'd0, mula} * {32'd0, mulb};
    assign rem_sh = {x_reg, y_reg[31]};
    assign rb = {1'b0, y_reg} + z_reg;

    always_comb begin
        busy_next = busy_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        w_next = w_reg;
        neg_next = neg_reg;
        arg_next = arg_reg;
        sts_next = '0;
        if (cmd.start) begin
            op_next = cmd.op;
            unique case (cmd.op)
                rpn_pkg::OP_ADD: sts_next = '{1'b1, 1'b0, a + b};
                rpn_pkg::OP_SUB: sts_next = '{1'b1, 1'b0, a - b};
                rpn_pkg::OP_MUL: begin
                    busy_next = 1'b1; x_next = a; y_next = b; z_next = '0;
                    cnt_next = 6'd0;
                end
                rpn_pkg::OP_DIV: begin
                    if (b == 32'd0) begin
                        sts_next = '{1'b1, 1'b1, 32'd0};
                    end else begin
                        busy_next = 1'b1; x_next = '0; y_next = abs_a;
                        z_next = {1'b0, abs_b}; neg_next = a[31] ^ b[31];
                        cnt_next = 6'd32;
                    end
                end
                rpn_pkg::OP_POW: begin
                    if (a == 32'd0) begin
                        sts_next = '{1'b1, b == 32'd0, 32'd0};
                    end else if (b[31]) begin
                        if (a == 32'd1) sts_next = '{1'b1, 1'b0, 32'd1};
                        else if (a == 32'hFFFF_FFFF)
                            sts_next = '{1'b1, 1'b0, b[0] ? 32'hFFFF_FFFF : 32'd1};
                        else sts_next = '{1'b1, 1'b0, 32'd0};
                    end else begin
                        busy_next = 1'b1; x_next = 32'd1; y_next = a;
                        z_next = {1'b0, b};
                    end
                end
                rpn_pkg::OP_SQRT: begin
                    if (a[31]) begin
                        sts_next = '{1'b1, 1'b1, 32'd0};
                    end else begin
                        busy_next = 1'b1; x_next = a; y_next = '0;
                        z_next = 33'h0_4000_0000;
                    end
                end
                rpn_pkg::OP_LOG: begin
                    if ($signed(b) <= 32'sd1 || $signed(a) <= 32'sd0) begin
                        sts_next = '{1'b1, 1'b1, 32'd0};
                    end else begin
                        busy_next = 1'b1; x_next = '0; z_next = 33'd1;
                        w_next = b; arg_next = a;
                    end
                end
                rpn_pkg::OP_SEL: sts_next = '{1'b1, 1'b0, (c == 32'd0) ? a : b};
                default: sts_next = '{1'b1, 1'b1, 32'd0};
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                rpn_pkg::OP_MUL: begin
                    busy_next = 1'b0;
                    sts_next = '{1'b1, 1'b0, prod[31:0]};
                end
                rpn_pkg::OP_DIV: begin
                    // restoring division, one quotient bit per step
                    if (rem_sh >= z_reg) x_next = 32'(rem_sh - z_reg);
                    else x_next = rem_sh[31:0];
                    y_next = {y_reg[30:0], rem_sh >= z_reg};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        busy_next = 1'b0;
                        sts_next = '{1'b1, 1'b0,
                            neg_reg ? (~y_next + 32'd1) : y_next};
                    end
                end
                rpn_pkg::OP_POW: begin
                    // odd exponent bit: acc *= sq, then sq *= sq next cycle
                    if (z_reg[31:0] == 32'd0) begin
                        busy_next = 1'b0;
                        sts_next = '{1'b1, 1'b0, x_reg};
                    end else if (z_reg[0]) begin
                        x_next = prod[31:0];
                        z_next = {z_reg[32:1], 1'b0};
                    end else begin
                        y_next = prod[31:0];
                        z_next = {1'b0, z_reg[32:1]};
                    end
                end
                rpn_pkg::OP_SQRT: begin
                    if (z_reg == 33'd0) begin
                        busy_next = 1'b0;
                        sts_next = '{1'b1, 1'b0, y_reg};
                    end else begin
                        if ({1'b0, x_reg} >= rb) begin
                            x_next = 32'({1'b0, x_reg} - rb);
                            y_next = {1'b0, y_reg[31:1]} + z_reg[31:0];
                        end else begin
                            y_next = {1'b0, y_reg[31:1]};
                        end
                        z_next = {2'b00, z_reg[32:2]};
                    end
                end
                default: begin
                    // log: p *= base until p >= arg
                    if (z_reg >= {1'b0, arg_reg}) begin
                        busy_next = 1'b0;
                        sts_next = '{1'b1, 1'b0, x_reg};
                    end else begin
                        x_next = x_reg + 32'd1;
                        z_next = (prod[63:32] != 32'd0) ? 33'h1_0000_0000
                                                         : {1'b0, prod[31:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sts <= '0;
        end else begin
            busy_reg <= busy_next;
            sts <= sts_next;
        end
        op_reg <= op_next;
        cnt_reg <= cnt_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        w_reg <= w_next;
        neg_reg <= neg_next;
        arg_reg <= arg_next;
    end
endmodule

// File: rtl/rpn_ctrl.sv
// Token sequencer: stack control, operand fetch, line status and output.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_top_macros.svh"
module rpn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [3:0]        s_type,
    input  logic [31:0]       s_value,
    input  logic              s_last,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [1:0]        m_status,
    output logic [31:0]       m_value,
    output logic              ram_we,
    output logic [rpn_pkg::PTR_W-1:0] ram_waddr,
    output logic [31:0]       ram_wdata,
    output logic [rpn_pkg::PTR_W-1:0] ram_raddr,
    input  logic [31:0]       ram_rdata,
    output rpn_pkg::rpn_cmd_t cmd,
    output logic [31:0]       opa,
    output logic [31:0]       opb,
    output logic [31:0]       opc,
    input  rpn_pkg::rpn_sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_RDC  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    localparam logic [rpn_pkg::CNT_W-1:0] DEPTH_C = rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);

    logic [2:0]  state_reg, state_next;
    logic [rpn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] last_reg, last_next;
    logic        have_reg, have_next, fail_reg, fail_next;
    logic [3:0]  op_reg, op_next;
    logic        eol_reg, eol_next;
    logic [1:0]  need_reg, need_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic        mv_reg, mv_next;
    logic [1:0]  ms_reg, ms_next;
    logic [31:0] mval_reg, mval_next;
    logic [1:0]  need;

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_status = ms_reg;
    assign m_value = mval_reg;
    assign opa = a_reg;
    assign opb = b_reg;
    assign opc = c_reg;

    always_comb begin
        unique case (s_type)
            rpn_pkg::OP_SQRT: need = 2'd1;
            rpn_pkg::OP_SEL:  need = 2'd3;
            default:          need = 2'd2;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        have_next = have_reg;
        fail_next = fail_reg;
        op_next = op_reg;
        eol_next = eol_reg;
        need_next = need_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        mv_next = mv_reg && !m_tready;
        ms_next = ms_reg;
        mval_next = mval_reg;
        ram_we = 1'b0;
        ram_waddr = cnt_reg[rpn_pkg::PTR_W-1:0];
        ram_wdata = s_value;
        ram_raddr = cnt_reg[rpn_pkg::PTR_W-1:0] - rpn_pkg::PTR_W'(1);
        cmd = '0;
        cmd.op = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next = s_type;
                    eol_next = s_last;
                    need_next = need;
                    state_next = S_END;
                    if (!fail_reg) begin
                        if (s_type == rpn_pkg::OP_PUSH) begin
                            if (cnt_reg >= DEPTH_C) begin
                                fail_next = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                cnt_next = cnt_reg + rpn_pkg::CNT_W'(1);
                            end
                        end else if (s_type > rpn_pkg::OP_SEL) begin
                            fail_next = 1'b1;
                        end else if (cnt_reg < rpn_pkg::CNT_W'(need)) begin
                            fail_next = 1'b1;
                        end else begin
                            state_next = S_RDA;
                        end
                    end
                end
            end
            S_RDA: begin
                // top entry was read at the accepting edge
                a_next = ram_rdata;
                ram_raddr = cnt_reg[rpn_pkg::PTR_W-1:0] - rpn_pkg::PTR_W'(2);
                state_next = S_RDB;
            end
            S_RDB: begin
                b_next = ram_rdata;
                ram_raddr = cnt_reg[rpn_pkg::PTR_W-1:0] - rpn_pkg::PTR_W'(3);
                state_next = S_RDC;
            end
            S_RDC: begin
                c_next = ram_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (sts.done) begin
                    if (sts.fail) begin
                        fail_next = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        ram_waddr = cnt_reg[rpn_pkg::PTR_W-1:0] - rpn_pkg::PTR_W'(need_reg);
                        ram_wdata = sts.result;
                        cnt_next = cnt_reg - rpn_pkg::CNT_W'(need_reg) + rpn_pkg::CNT_W'(1);
                        last_next = sts.result;
                        have_next = 1'b1;
                    end
                    state_next = S_END;
                end
            end
            default: begin
                state_next = S_IDLE;
                if (eol_reg) begin
                    mv_next = 1'b1;
                    ms_next = fail_reg ? rpn_pkg::ST_ERROR
                            : have_reg ? rpn_pkg::ST_VALID : rpn_pkg::ST_NONE;
                    mval_next = (!fail_reg && have_reg) ? last_reg : 32'd0;
                    cnt_next = '0;
                    last_next = '0;
                    have_next = 1'b0;
                    fail_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            last_reg <= '0;
            have_reg <= 1'b0;
            fail_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            have_reg <= have_next;
            fail_reg <= fail_next;
            mv_reg <= mv_next;
        end
        op_reg <= op_next;
        eol_reg <= eol_next;
        need_reg <= need_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        ms_reg <= ms_next;
        mval_reg <= mval_next;
    end

    `RPN_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= DEPTH_C)
    `RPN_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready)
    `RPN_ASSERT_IMP(a_err_zero, aclk, aresetn, mv_reg && ms_reg != rpn_pkg::ST_VALID, mval_reg == 32'd0)
    `RPN_ASSERT_NXT(a_start_wait, aclk, aresetn, state_reg == S_EXEC, state_reg == S_WAIT)
endmodule

// File: rtl/rpn_stack_calculator_top.sv
// Top level of the integer RPN calculator.
`timescale 1ns / 1ps
// Integer RPN calculator, one token per input request. An operator reads
// three entries from the stack RAM (one read port, registered) and then runs
// in the iterative ALU: add/sub/select finish at once, multiply in one step,
// divide in 32 steps, power by square-and-multiply, root in 16, log in up to
// 32. A result is sent only on a line's last token; the next token is taken
// once that result has been taken.
module rpn_stack_calculator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [3:0]  s_tuser,   // [3:0] req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] line_status
);
    rpn_pkg::rpn_cmd_t cmd;
    rpn_pkg::rpn_sts_t sts;
    logic ram_we;
    logic [rpn_pkg::PTR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata, opa, opb, opc;

    rpn_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .s_type(s_tuser), .s_value(s_tdata), .s_last(s_tlast),
        .m_tvalid, .m_tready, .m_status(m_tuser), .m_value(m_tdata),
        .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata,
        .cmd, .opa, .opb, .opc, .sts
    );

    rpn_ram #(.WIDTH(32), .DEPTH(rpn_pkg::STACK_DEPTH)) u_stack (
        .aclk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    rpn_alu u_alu (
        .aclk, .aresetn, .cmd, .a(opa), .b(opb), .c(opc), .sts
    );
endmodule
